FILE: hdl/lsog_pkg.sv
// Shared types, codes, constants and the quarter-degree trig table of the occupancy grid.
package lsog_pkg;

  localparam int CELL_W = 2;

  localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
  localparam logic [CELL_W-1:0] CELL_LANE  = 2'd1;
  localparam logic [CELL_W-1:0] CELL_OBST  = 2'd2;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_RAY   = 2'd1;
  localparam logic [1:0] CMD_LANE  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LIDAR_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_ROW_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_MAP_WIDTH  = 2'd3;

  localparam logic signed [6:0] LIDAR_OFFSET_RST    = -7'sd6;
  localparam logic [7:0]        NEAR_LIMIT_RST      = 8'd5;
  localparam logic [7:0]        LANE_ROW_OFFSET_RST = 8'd8;
  localparam logic [9:0]        LANE_MAP_WIDTH_RST  = 10'd400;

  localparam int RANGE_DEF      = 200;
  localparam int DOWNSAMPLE_DEF = 6;
  localparam int GRID_WIDTH     = 480;
  localparam int SCAN_RAYS      = 720;
  localparam int COARSE_ROWS    = 64;
  localparam int COARSE_COLS    = 128;

  localparam logic [7:0] LANE_VALUE_SET = 8'd2;

  // Ray arithmetic: Q8.8 range times Q1.15 trig times 20 cells a metre, back by 23 bits.
  localparam int CELLS_PER_METRE = 20;
  localparam int CELL_SHIFT      = 23;
  localparam int RAY_N_W         = 12;

  // Trig table: angle |n| * 3.14 / 720, Taylor series in Q6.26, rounded to Q1.15.
  localparam int PI_X100    = 314;
  localparam int ANGLE_DIV  = 72000;
  localparam int TRIG_FRAC  = 26;
  localparam int TRIG_TERMS = 24;
  localparam int Q15_SHIFT  = TRIG_FRAC - 15;
  localparam int TRIG_DEPTH = 1025;
  localparam int TRIG_AW    = $clog2(TRIG_DEPTH);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  scan_index;
    logic [15:0] range_value;
    logic [9:0]  lane_row;
    logic [9:0]  lane_col;
    logic [7:0]  lane_value;
    logic [5:0]  coarse_row;
    logic [6:0]  coarse_col;
  } lsog_in_t;

  typedef struct packed {
    logic [1:0] cell_class;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } lsog_out_t;

  // Each entry holds the sine in the upper and the cosine in the lower half.
  typedef logic [31:0] trig_tab_t [TRIG_DEPTH];

  function automatic logic [15:0] q15_round(input longint v);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + (longint'(1) << (Q15_SHIFT - 1))) >>> Q15_SHIFT;
    if (v < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic trig_tab_t build_trig_tab();
    trig_tab_t tab;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint s;
    longint c;
    for (int a = 0; a < TRIG_DEPTH; a++) begin
      th = (((64'(a) * 64'(PI_X100)) << TRIG_FRAC) + 64'(ANGLE_DIV / 2)) / 64'(ANGLE_DIV);
      x2 = (th * th) >> TRIG_FRAC;
      ts = th;
      tc = 64'd1 << TRIG_FRAC;
      s = 0;
      c = 0;
      for (int k = 0; k < TRIG_TERMS; k++) begin
        if (k[0]) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
        ts = ((ts * x2) >> TRIG_FRAC) / 64'((2 * k + 2) * (2 * k + 3));
        tc = ((tc * x2) >> TRIG_FRAC) / 64'((2 * k + 1) * (2 * k + 2));
      end
      tab[a] = {q15_round(s), q15_round(c)};
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig_tab();

endpackage

FILE: hdl/lidar_scan_occupancy_grid_top.sv
// Lidar and lane occupancy grid: row-wide grid memory with read-modify-write control.
//
// Items arrive on a valid/ready input channel; one transfer carries a command and its
// fields. Clear empties the grid, a ray marks an obstacle cell, a lane item marks a lane
// cell that holds no obstacle, and a read returns one coarse cell on the valid/ready
// output channel. Only reads produce a result. Configuration is a plain write port.
// The grid lives in one memory of RANGE+1 rows, each row a word of 2*RANGE+1 cells;
// every cell update reads its row and writes it back in the next cycle.
// Items are handled one at a time; the input is ready only while the controller waits.
// A lane item that marks a cell takes a row read and write; a ray that marks one takes index
// split, table read, multiply, rounding, window check, row read and row write. A clear
// empties one row per cycle, a read fetches one fine row per cycle through a registered
// shifter. A dropped lane item or ray index returns to waiting at once, a ray outside the
// window after its window check. A read result is loaded once its row walk is done.
// After reset the controller clears all RANGE+1 rows before taking any item; config
// registers return to their default values.
// A result waits in the output register while the receiver stalls; the block still takes
// new items, and only a following read waits until that register is free.
module lidar_scan_occupancy_grid_top #(
  parameter int RANGE      = lsog_pkg::RANGE_DEF,
  parameter int DOWNSAMPLE = lsog_pkg::DOWNSAMPLE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lsog_pkg::lsog_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lsog_pkg::lsog_out_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [lsog_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lsog_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import lsog_pkg::*;

  localparam int GridRows = RANGE + 1;
  localparam int GridCols = 2 * RANGE + 1;
  localparam int RowW     = $clog2(GridRows);
  localparam int ColW     = $clog2(GridCols);
  localparam int RowBits  = CELL_W * GridCols;
  localparam int WinBits  = CELL_W * DOWNSAMPLE;
  localparam int ExtBits  = RowBits + WinBits;
  localparam int FrW      = $clog2(COARSE_ROWS * DOWNSAMPLE);
  localparam int IssW     = $clog2(DOWNSAMPLE + 1);
  localparam int SelW     = $clog2(COARSE_COLS * DOWNSAMPLE + RANGE + DOWNSAMPLE + GRID_WIDTH) + 1;
  localparam int SelOff   = RANGE + DOWNSAMPLE - GRID_WIDTH / 2;
  localparam int HalfRays = SCAN_RAYS / 2;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_RAY_ROM  = 4'd2;
  localparam logic [3:0] ST_RAY_MUL  = 4'd3;
  localparam logic [3:0] ST_RAY_CELL = 4'd4;
  localparam logic [3:0] ST_RAY_CHK  = 4'd5;
  localparam logic [3:0] ST_RMW_RD   = 4'd6;
  localparam logic [3:0] ST_RMW_WR   = 4'd7;
  localparam logic [3:0] ST_RD_ROWS  = 4'd8;
  localparam logic [3:0] ST_RD_DONE  = 4'd9;

  // Cell count of one product: times 20, then rounded half away from zero by 23 bits.
  function automatic logic signed [14:0] cell_round(input logic signed [33:0] p);
    logic signed [38:0] s;
    logic [38:0] mag;
    logic [38:0] q;
    s = 39'(p) * 39'(CELLS_PER_METRE);
    mag = s[38] ? 39'(-s) : 39'(s);
    q = (mag + (39'd1 << (CELL_SHIFT - 1))) >> CELL_SHIFT;
    return s[38] ? -15'(q) : 15'(q);
  endfunction

  logic [3:0]              state_q, state_d;
  logic [RowW-1:0]         clr_cnt_q, clr_cnt_d;
  logic [IssW-1:0]         iss_q, iss_d;
  logic                    rd_vld_q, win_vld_q;
  logic                    out_valid_q;
  lsog_out_t               out_q;

  logic signed [6:0]       lidar_offset_q;
  logic [7:0]              near_limit_q;
  logic [7:0]              lane_row_offset_q;
  logic [9:0]              lane_map_width_q;

  logic [TRIG_AW-1:0]      absn_q;
  logic                    neg_q;
  logic [15:0]             range_q;
  logic [31:0]             trig_q;
  logic signed [33:0]      prod_x_q, prod_y_q;
  logic signed [14:0]      xr_q, yr_q;

  logic [RowW-1:0]         tgt_row_q;
  logic [ColW-1:0]         tgt_col_q;
  logic                    tgt_lane_q;

  logic [5:0]              cr_q;
  logic [6:0]              cc_q;
  logic                    sel_neg_q;
  logic [SelW-2:0]         sel_amt_q;
  logic                    rd_inrow_q;
  logic [WinBits-1:0]      win_q;
  logic [CELL_W-1:0]       acc_q, acc_d;

  logic [RowBits-1:0]      grid_mem [GridRows];
  logic [RowBits-1:0]      mem_rdata_q;
  logic [RowBits-1:0]      mem_wdata;
  logic [RowW-1:0]         mem_raddr, mem_waddr;
  logic                    mem_we, mem_re;

  logic                    in_acc;
  logic                    out_load;
  logic                    ray_ok;
  logic signed [RAY_N_W-1:0] ray_n, ray_abs;
  logic signed [11:0]      lane_rowd, lane_yd;
  logic [11:0]             lane_colw;
  logic                    lane_ok;
  logic [SelW-1:0]         sel_c;
  logic signed [16:0]      sin_s;
  logic signed [15:0]      x_c, y_c;
  logic [15:0]             ray_colw;
  logic                    ray_hit;
  logic [FrW-1:0]          fr;
  logic                    fr_inrow;
  logic [SelW-1:0]         sh_amt;
  logic [ExtBits-1:0]      ext;
  logic [WinBits-1:0]      win_c;
  logic [CELL_W-1:0]       cell_old;
  logic [RowBits-1:0]      row_mod;

  assign in_acc = in_valid_i & in_ready_o;

  // Item decode, taken at the transfer.
  always_comb begin
    ray_ok    = {2'b00, in_data_i.scan_index} < RAY_N_W'(SCAN_RAYS);
    ray_n     = $signed({2'b00, in_data_i.scan_index}) - $signed(RAY_N_W'(HalfRays));
    ray_abs   = ray_n[RAY_N_W-1] ? -ray_n : ray_n;
    lane_rowd = $signed({2'b00, in_data_i.lane_row}) - $signed({4'b0000, lane_row_offset_q});
    lane_yd   = $signed({2'b00, in_data_i.lane_col}) - $signed({3'b000, lane_map_width_q[9:1]});
    lane_colw = 12'(lane_yd) + 12'(RANGE);
    lane_ok   = (in_data_i.lane_value == LANE_VALUE_SET) && !lane_rowd[11] &&
                (lane_rowd <= $signed(12'(RANGE))) &&
                (in_data_i.lane_col < lane_map_width_q) &&
                (lane_yd <= $signed(12'(RANGE))) && (lane_yd >= -$signed(12'(RANGE)));
    sel_c     = SelW'(in_data_i.coarse_col) * SelW'(DOWNSAMPLE) + SelW'(SelOff);
  end

  // Ray geometry after rounding.
  always_comb begin
    sin_s    = neg_q ? -17'($signed(trig_q[31:16])) : 17'($signed(trig_q[31:16]));
    x_c      = 16'(xr_q) + 16'(lidar_offset_q);
    y_c      = -16'(yr_q);
    ray_colw = 16'(y_c) + 16'(RANGE);
    ray_hit  = (x_c > $signed({8'b0, near_limit_q})) && (x_c <= $signed(16'(RANGE))) &&
               (y_c <= $signed(16'(RANGE))) && (y_c >= -$signed(16'(RANGE))) &&
               !((xr_q == '0) && (yr_q == '0));
  end

  // Coarse read: fine row to fetch, and the window of cells taken out of a fetched row.
  // The row is padded below by one window of empty cells so that a window starting left
  // of the grid still lines up; cells right of the grid shift in as empty.
  always_comb begin
    fr       = FrW'(cr_q) * FrW'(DOWNSAMPLE) + FrW'(iss_q);
    fr_inrow = int'(fr) <= RANGE;
    sh_amt   = SelW'({1'b0, sel_amt_q}) * SelW'(CELL_W);
    ext      = {mem_rdata_q, {WinBits{1'b0}}};
    win_c    = sel_neg_q ? '0 : WinBits'(ext >> sh_amt);
    acc_d    = acc_q;
    for (int m = 0; m < DOWNSAMPLE; m++) begin
      if (win_q[CELL_W*m +: CELL_W] != CELL_EMPTY) acc_d = win_q[CELL_W*m +: CELL_W];
    end
  end

  // Single-cell update of a fetched row; an obstacle is never turned into lane.
  always_comb begin
    cell_old = mem_rdata_q[CELL_W*tgt_col_q +: CELL_W];
    row_mod  = mem_rdata_q;
    if (!tgt_lane_q) begin
      row_mod[CELL_W*tgt_col_q +: CELL_W] = CELL_OBST;
    end else if (cell_old != CELL_OBST) begin
      row_mod[CELL_W*tgt_col_q +: CELL_W] = CELL_LANE;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    iss_d      = iss_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = tgt_row_q;
    out_load   = 1'b0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_q == RowW'(GridRows - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.cmd)
            CMD_CLEAR: begin
              state_d   = ST_CLEAR;
              clr_cnt_d = '0;
            end
            CMD_RAY: begin
              if (ray_ok) state_d = ST_RAY_ROM;
            end
            CMD_LANE: begin
              if (lane_ok) state_d = ST_RMW_RD;
            end
            CMD_READ: begin
              state_d = ST_RD_ROWS;
              iss_d   = '0;
            end
          endcase
        end
      end
      ST_RAY_ROM: state_d = ST_RAY_MUL;
      ST_RAY_MUL: state_d = ST_RAY_CELL;
      ST_RAY_CELL: state_d = ST_RAY_CHK;
      ST_RAY_CHK: begin
        state_d = ray_hit ? ST_RMW_RD : ST_IDLE;
      end
      ST_RMW_RD: begin
        mem_re  = 1'b1;
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_row_q;
        mem_wdata = row_mod;
        state_d   = ST_IDLE;
      end
      ST_RD_ROWS: begin
        if (iss_q != IssW'(DOWNSAMPLE)) begin
          mem_re    = fr_inrow;
          mem_raddr = fr_inrow ? RowW'(fr) : '0;
          iss_d     = iss_q + 1'b1;
        end else if (!rd_vld_q && !win_vld_q) begin
          state_d = ST_RD_DONE;
        end
      end
      ST_RD_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      win_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      iss_q     <= iss_d;
      rd_vld_q  <= (state_q == ST_RD_ROWS) && (iss_q != IssW'(DOWNSAMPLE));
      win_vld_q <= rd_vld_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lidar_offset_q    <= LIDAR_OFFSET_RST;
      near_limit_q      <= NEAR_LIMIT_RST;
      lane_row_offset_q <= LANE_ROW_OFFSET_RST;
      lane_map_width_q  <= LANE_MAP_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LIDAR_OFFSET:    lidar_offset_q    <= cfg_wdata_i[6:0];
        CFG_NEAR_LIMIT:      near_limit_q      <= cfg_wdata_i[7:0];
        CFG_LANE_ROW_OFFSET: lane_row_offset_q <= cfg_wdata_i[7:0];
        CFG_LANE_MAP_WIDTH:  lane_map_width_q  <= cfg_wdata_i;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      absn_q    <= ray_abs[TRIG_AW-1:0];
      neg_q     <= ray_n[RAY_N_W-1];
      range_q   <= in_data_i.range_value;
      cr_q      <= in_data_i.coarse_row;
      cc_q      <= in_data_i.coarse_col;
      sel_neg_q <= sel_c[SelW-1];
      sel_amt_q <= sel_c[SelW-2:0];
      acc_q     <= CELL_EMPTY;
    end else if (win_vld_q) begin
      acc_q <= acc_d;
    end
    if (in_acc && (in_data_i.cmd == CMD_LANE)) begin
      tgt_row_q  <= lane_rowd[RowW-1:0];
      tgt_col_q  <= lane_colw[ColW-1:0];
      tgt_lane_q <= 1'b1;
    end else if (state_q == ST_RAY_CHK) begin
      tgt_row_q  <= x_c[RowW-1:0];
      tgt_col_q  <= ray_colw[ColW-1:0];
      tgt_lane_q <= 1'b0;
    end
    if (state_q == ST_RAY_ROM) begin
      trig_q <= TRIG_TAB[absn_q];
    end
    if (state_q == ST_RAY_MUL) begin
      prod_x_q <= $signed({1'b0, range_q}) * $signed(trig_q[15:0]);
      prod_y_q <= $signed({1'b0, range_q}) * sin_s;
    end
    if (state_q == ST_RAY_CELL) begin
      xr_q <= cell_round(prod_x_q);
      yr_q <= cell_round(prod_y_q);
    end
    if (rd_vld_q) begin
      win_q <= rd_inrow_q ? win_c : '0;
    end
    if ((state_q == ST_RD_ROWS) && (iss_q != IssW'(DOWNSAMPLE))) begin
      rd_inrow_q <= fr_inrow;
    end
    if (out_load) begin
      out_q.cell_class <= acc_q;
      out_q.read_row   <= cr_q;
      out_q.read_col   <= cc_q;
    end
  end

  // Grid memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= grid_mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_write_in_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_ROWS) |-> !mem_we)
    else $error("grid written during a coarse read");

  a_result_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RD_DONE))
    else $error("result raised without a finished coarse read");

  a_rmw_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW_WR) |-> $past(state_q == ST_RMW_RD))
    else $error("row write-back without its read");

  a_write_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (int'(mem_waddr) < GridRows))
    else $error("grid write beyond the last row");

  a_walk_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || win_vld_q) |-> (state_q == ST_RD_ROWS))
    else $error("coarse read pipeline active outside the row walk");

endmodule
